### sv/kpd_pkg.sv
// Package for the ladder keypad decoder: widths, codes, register reset values
// and the structs passed between the decoder modules. No dependencies.
`timescale 1ns / 1ps

package kpd_pkg;

   localparam int unsigned SampleWidth   = 8;
   localparam int unsigned KeyWidth      = 3;
   localparam int unsigned HoldWidth     = 16;
   localparam int unsigned NumKeys       = 6;
   localparam int unsigned WantWidth     = 4;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 48;

   typedef logic [SampleWidth-1:0] sample_type;
   typedef logic [KeyWidth-1:0]    key_type;
   typedef logic [HoldWidth-1:0]   hold_type;
   typedef logic [WantWidth-1:0]   want_type;

   localparam key_type NoKey = 3'd6;

   // bit positions within one key's wants nibble
   localparam int unsigned WantPress   = 0;
   localparam int unsigned WantRelease = 1;
   localparam int unsigned WantRepeat  = 2;
   localparam int unsigned WantLong    = 3;

   typedef enum logic [1:0] {
      EvPress   = 2'd0,
      EvRelease = 2'd1,
      EvLong    = 2'd2,
      EvRepeat  = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      RepNone = 2'd0,
      RepAuto = 2'd1,
      RepLong = 2'd2
   } repeat_status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegBoundaries = 3'd0,
      RegWants      = 3'd1,
      RegNoise      = 3'd2,
      RegLongCount  = 3'd3,
      RegRepStart   = 3'd4,
      RegRepPeriod  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NumKeys*SampleWidth-1:0] boundaries;
      logic [NumKeys*WantWidth-1:0]   wants;
      sample_type                     noise_limit;
      hold_type                       long_count;
      hold_type                       rep_start;
      hold_type                       rep_period;
   } cfg_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      key_type        key;
   } event_type;

   localparam logic [NumKeys*SampleWidth-1:0] BoundariesReset = 48'hDCB48C643C14;
   localparam logic [NumKeys*WantWidth-1:0]   WantsReset      = 24'h666666;
   localparam sample_type                     NoiseReset      = 8'd4;
   localparam hold_type                       LongCountReset  = 16'd100;
   localparam hold_type                       RepStartReset   = 16'd50;
   localparam hold_type                       RepPeriodReset  = 16'd10;
   localparam sample_type                     SampleMax       = 8'hFF;

endpackage

### sv/kpd_csr.sv
// Configuration registers of the ladder keypad decoder.
// Depends on kpd_pkg for the register map and reset values.
`timescale 1ns / 1ps

module kpd_csr import kpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundaries  <= BoundariesReset;
         cfg_ff.wants       <= WantsReset;
         cfg_ff.noise_limit <= NoiseReset;
         cfg_ff.long_count  <= LongCountReset;
         cfg_ff.rep_start   <= RepStartReset;
         cfg_ff.rep_period  <= RepPeriodReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            RegBoundaries: begin
               cfg_ff.boundaries <= csr_wdata[NumKeys*SampleWidth-1:0];
            end
            RegWants: begin
               cfg_ff.wants <= csr_wdata[NumKeys*WantWidth-1:0];
            end
            RegNoise: begin
               cfg_ff.noise_limit <= csr_wdata[SampleWidth-1:0];
            end
            RegLongCount: begin
               cfg_ff.long_count <= csr_wdata[HoldWidth-1:0];
            end
            RegRepStart: begin
               cfg_ff.rep_start <= csr_wdata[HoldWidth-1:0];
            end
            RegRepPeriod: begin
               cfg_ff.rep_period <= csr_wdata[HoldWidth-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/kpd_event.sv
// Key state tracking and event generation for the ladder keypad decoder:
// noise gate, ladder classification, hold counter and autorepeat state.
// Depends on kpd_pkg.
`timescale 1ns / 1ps

module kpd_event import kpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_fire,
   input  sample_type sample,
   input  cfg_type    cfg,
   output event_type  evt
);

   sample_type        prev_ff;
   key_type           key_ff;
   hold_type          hold_ff;
   repeat_status_type status_ff;

   key_type           key_in;
   hold_type          hold_in;
   repeat_status_type status_in;

   logic [SampleWidth:0] diff;
   logic                 used;
   key_type              new_key;
   want_type             w_new;
   want_type             w_old;
   hold_type             hold_inc;

   function automatic want_type wants_of(input cfg_type c, input key_type k);
      want_type w;
      w = '0;
      case (k)
         3'd0: w = c.wants[0*WantWidth +: WantWidth];
         3'd1: w = c.wants[1*WantWidth +: WantWidth];
         3'd2: w = c.wants[2*WantWidth +: WantWidth];
         3'd3: w = c.wants[3*WantWidth +: WantWidth];
         3'd4: w = c.wants[4*WantWidth +: WantWidth];
         3'd5: w = c.wants[5*WantWidth +: WantWidth];
         default: w = '0;
      endcase
      return w;
   endfunction

   // lowest boundary that the sample is below decides
   always_comb begin
      new_key = NoKey;
      for (int i = NumKeys - 1; i >= 0; i--) begin
         if (sample < cfg.boundaries[i*SampleWidth +: SampleWidth]) begin
            new_key = key_type'(NumKeys - 1 - i);
         end
      end
   end

   always_comb begin
      diff = (prev_ff > sample) ? ({1'b0, prev_ff} - {1'b0, sample})
                                : ({1'b0, sample} - {1'b0, prev_ff});
      used = diff < {1'b0, cfg.noise_limit};
   end

   assign w_new    = wants_of(cfg, new_key);
   assign w_old    = wants_of(cfg, key_ff);
   assign hold_inc = hold_ff + 16'd1;

   always_comb begin
      key_in    = key_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      evt       = '{valid: 1'b0, kind: EvPress, key: new_key};
      if (used) begin
         if (key_ff != new_key) begin
            if (key_ff == NoKey) begin
               key_in    = new_key;
               hold_in   = '0;
               status_in = RepNone;
               if (w_new[WantPress]) begin
                  evt = '{valid: 1'b1, kind: EvPress, key: new_key};
               end
            end else begin
               // a jump straight to another key counts as a release
               key_in = NoKey;
               if (w_old[WantRelease] && status_ff == RepNone) begin
                  evt = '{valid: 1'b1, kind: EvRelease, key: key_ff};
               end
            end
         end else if (new_key != NoKey) begin
            hold_in = hold_inc;
            if (hold_inc == cfg.long_count && w_new[WantLong]) begin
               evt       = '{valid: 1'b1, kind: EvLong, key: new_key};
               status_in = RepLong;
            end
            if (w_new[WantRepeat]) begin
               if (status_in == RepNone) begin
                  if (hold_inc == cfg.rep_start) begin
                     status_in = RepAuto;
                     hold_in   = '0;
                     evt       = '{valid: 1'b1, kind: EvRepeat, key: new_key};
                  end
               end else if (status_in == RepAuto && hold_inc == cfg.rep_period) begin
                  hold_in = '0;
                  evt     = '{valid: 1'b1, kind: EvRepeat, key: new_key};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= SampleMax;
         key_ff    <= NoKey;
         hold_ff   <= '0;
         status_ff <= RepNone;
      end else if (item_fire) begin
         prev_ff   <= sample;
         key_ff    <= key_in;
         hold_ff   <= hold_in;
         status_ff <= status_in;
      end
   end

endmodule

### sv/ladder_keypad_decoder.sv
// Ladder keypad decoder: takes one converter sample per item on req_ and
// gives zero or one key event per item on rsp_. One item is taken every
// cycle unless the flow stops; an item goes through the input register, then
// decode logic into the result register. The flow stops only while a result
// is held on rsp_ with rsp_tready low, in which case one more item is still
// taken into the input register. Configuration writes on csr_ take effect at
// once and are meant for times when no item is in flight.
`timescale 1ns / 1ps

module ladder_keypad_decoder import kpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] sample
   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [2:0] key_index, [7:3] zero
   output logic [1:0]               rsp_tuser,   // [1:0] event_kind
   // configuration
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   event_type  evt;

   logic       in_valid_ff;
   sample_type in_sample_ff;
   logic       out_valid_ff;
   key_type    out_key_ff;
   event_kind_type out_kind_ff;

   logic       advance;
   logic       item_fire;

   kpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpd_event u_event (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .sample    (in_sample_ff),
      .cfg       (cfg),
      .evt       (evt)
   );

   // result register free or being emptied this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign item_fire  = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata[SampleWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= item_fire && evt.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_key_ff  <= evt.key;
         out_kind_ff <= evt.kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_key_ff};
   assign rsp_tuser  = out_kind_ff;

endmodule
